### rtl/igcm_pkg.sv
`timescale 1ns / 1ps

package igcm_pkg;

    localparam int MAX_INTERVALS_DEF = 16;
    localparam int COORD_W           = 32;
    localparam int STATUS_W          = 3;

    typedef enum logic [1:0] {
        KIND_CLEAR    = 2'd0,
        KIND_APPEND   = 2'd1,
        KIND_TO_FUSED = 2'd2,
        KIND_TO_ORIG  = 2'd3
    } kind_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVF   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ORDER = 3'd4;

    // one table row: all four columns are written together by an append
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] fused_end;
        logic signed [COORD_W-1:0] disp;
    } entry_t;

endpackage

### rtl/interval_gap_compaction_map_top.sv
`timescale 1ns / 1ps

// Interval table with gap compaction and point mapping.
// Input channel (s_valid/s_ready): one request per item. s_kind selects
// clear, append of [s_point_or_left, s_right_end], original-to-fused or
// fused-to-original mapping of s_point_or_left.
// Result channel (m_valid/m_ready): exactly one result per request,
// m_mapped_value and m_status, in request order.
// Clear, append, single-interval and out-of-range queries pass through
// S_EXEC and S_FINISH, where the result is loaded into the output register.
// A query that walks the table adds S_SCAN, which reads one row per cycle
// from the table memory, up to MAX_INTERVALS rows, before S_FINISH.
// One request is in work at a time; s_ready is high only while idle.
// The finished result sits in an output register; s_ready comes back as
// soon as the result is loaded there, so a new request is taken while the
// receiver still stalls. A result waits in the sequencer if the output
// register is still full.
// Reset (aresetn, synchronous, active low) empties the table by zeroing the
// count; no clearing pass. Clear keeps the stored rows, only the count drops.
module interval_gap_compaction_map_top #(
    parameter int MAX_INTERVALS = igcm_pkg::MAX_INTERVALS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_kind,
    input  logic signed [igcm_pkg::COORD_W-1:0]  s_point_or_left,
    input  logic signed [igcm_pkg::COORD_W-1:0]  s_right_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [igcm_pkg::COORD_W-1:0]  m_mapped_value,
    output logic [igcm_pkg::STATUS_W-1:0]        m_status
);

    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int W  = igcm_pkg::COORD_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_INTERVALS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    igcm_pkg::kind_t kind_reg, kind_next;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] r_reg, r_next;
    logic signed [W-1:0] left0_reg, left0_next;
    logic signed [W-1:0] last_right_reg, last_right_next;
    logic signed [W-1:0] last_fe_reg, last_fe_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic signed [W-1:0] res_value_reg, res_value_next;
    logic [igcm_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic m_valid_reg, m_valid_next;
    logic signed [W-1:0] m_value_reg, m_value_next;
    logic [igcm_pkg::STATUS_W-1:0] m_status_reg, m_status_next;

    // table memory
    igcm_pkg::entry_t mem [MAX_INTERVALS];
    igcm_pkg::entry_t rd_data_reg;
    igcm_pkg::entry_t mem_wdata;
    logic [AW-1:0] mem_addr;
    logic mem_we;

    // append arithmetic, 34 bits wide so overflow is visible
    logic signed [W+1:0] span_w;
    logic signed [W+1:0] fe_w;
    logic signed [W+1:0] dp_w;
    logic fe_fits, dp_fits;
    logic app_full, app_order;
    logic signed [W-1:0] miss_value;
    logic signed [W-1:0] hi_bound;
    logic [AW-1:0] last_idx;

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_mapped_value = m_value_reg;
    assign m_status       = m_status_reg;

    assign miss_value = left0_reg - W'(1);
    assign last_idx   = AW'(count_reg - CNT_ONE);
    assign hi_bound   = (kind_reg == igcm_pkg::KIND_TO_FUSED) ? last_right_reg : last_fe_reg;

    assign span_w    = (W+2)'(r_reg) - (W+2)'(x_reg);
    assign fe_w      = (count_reg == '0) ? (W+2)'(r_reg) : (W+2)'(last_fe_reg) + span_w;
    assign dp_w      = (count_reg == '0) ? '0 : (W+2)'(x_reg) - (W+2)'(last_fe_reg);
    assign fe_fits   = (fe_w[W+1:W-1] == 3'b000) || (fe_w[W+1:W-1] == 3'b111);
    assign dp_fits   = (dp_w[W+1:W-1] == 3'b000) || (dp_w[W+1:W-1] == 3'b111);
    assign app_full  = (count_reg == CNT_MAX);
    assign app_order = (r_reg < x_reg) || ((count_reg != '0) && (x_reg < last_right_reg));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        kind_next       = kind_reg;
        x_next          = x_reg;
        r_next          = r_reg;
        left0_next      = left0_reg;
        last_right_next = last_right_reg;
        last_fe_next    = last_fe_reg;
        idx_next        = idx_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_we          = 1'b0;
        mem_addr        = idx_reg;
        mem_wdata.left      = x_reg;
        mem_wdata.right     = r_reg;
        mem_wdata.fused_end = fe_w[W-1:0];
        mem_wdata.disp      = dp_w[W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next  = igcm_pkg::kind_t'(s_kind);
                    x_next     = s_point_or_left;
                    r_next     = s_right_end;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FINISH;
                unique case (kind_reg)
                    igcm_pkg::KIND_CLEAR: begin
                        count_next      = '0;
                        res_value_next  = '0;
                        res_status_next = igcm_pkg::ST_OK;
                    end
                    igcm_pkg::KIND_APPEND: begin
                        res_value_next = '0;
                        priority if (app_full) begin
                            res_status_next = igcm_pkg::ST_FULL;
                        end else if (app_order) begin
                            res_status_next = igcm_pkg::ST_ORDER;
                        end else if (!fe_fits || !dp_fits) begin
                            res_status_next = igcm_pkg::ST_OVF;
                        end else begin
                            mem_we          = 1'b1;
                            mem_addr        = AW'(count_reg);
                            count_next      = count_reg + CNT_ONE;
                            if (count_reg == '0) begin
                                left0_next = x_reg;
                            end
                            last_right_next = r_reg;
                            last_fe_next    = fe_w[W-1:0];
                            res_value_next  = fe_w[W-1:0];
                            res_status_next = igcm_pkg::ST_OK;
                        end
                    end
                    igcm_pkg::KIND_TO_FUSED, igcm_pkg::KIND_TO_ORIG: begin
                        priority if (count_reg == CNT_ONE) begin
                            res_value_next  = x_reg;
                            res_status_next = igcm_pkg::ST_OK;
                        end else if ((count_reg == '0) || (x_reg < left0_reg)
                                     || (x_reg > hi_bound)) begin
                            res_value_next  = miss_value;
                            res_status_next = igcm_pkg::ST_MISS;
                        end else begin
                            // inside the covered range the walk always stops on a row
                            mem_addr   = (kind_reg == igcm_pkg::KIND_TO_FUSED) ? last_idx : '0;
                            idx_next   = mem_addr;
                            state_next = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (kind_reg == igcm_pkg::KIND_TO_FUSED) begin
                    // walk down: last row whose left end is at or below x
                    if (rd_data_reg.left <= x_reg) begin
                        state_next = S_FINISH;
                        if (rd_data_reg.right >= x_reg) begin
                            res_value_next  = x_reg - rd_data_reg.disp;
                            res_status_next = igcm_pkg::ST_OK;
                        end else begin
                            res_value_next  = miss_value;
                            res_status_next = igcm_pkg::ST_MISS;
                        end
                    end else begin
                        mem_addr = idx_reg - AW'(1);
                        idx_next = mem_addr;
                    end
                end else begin
                    // walk up: first row whose fused end is at or above x
                    if (rd_data_reg.fused_end >= x_reg) begin
                        state_next      = S_FINISH;
                        res_value_next  = x_reg + rd_data_reg.disp;
                        res_status_next = igcm_pkg::ST_OK;
                    end else begin
                        mem_addr = idx_reg + AW'(1);
                        idx_next = mem_addr;
                    end
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg       <= kind_next;
        x_reg          <= x_next;
        r_reg          <= r_next;
        left0_reg      <= left0_next;
        last_right_reg <= last_right_next;
        last_fe_reg    <= last_fe_next;
        idx_reg        <= idx_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // count never runs past the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("interval count above table size");

    // a table walk only happens with two or more rows
    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (count_reg > CNT_ONE))
        else $error("table walk with fewer than two intervals");

    // a new result appears only when the sequencer hands it over
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) && (m_valid_next) |-> (state_reg == S_FINISH))
        else $error("result loaded outside finish state");

    // an accepted request always starts work in the next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

endmodule

### tb/interval_gap_compaction_map_top_tb.sv
`timescale 1ns / 1ps

module interval_gap_compaction_map_top_tb;

    localparam int     MAXI   = igcm_pkg::MAX_INTERVALS_DEF;
    localparam int     CW     = igcm_pkg::COORD_W;
    localparam int     SW     = igcm_pkg::STATUS_W;
    localparam longint Q_MIN  = -(64'sd1 <<< 31);
    localparam longint Q_MAX  = (64'sd1 <<< 31) - 1;
    localparam logic [31:0] QMIN32 = 32'h8000_0000;
    localparam logic [31:0] QMAX32 = 32'h7FFF_FFFF;

    typedef struct {
        logic [CW-1:0] value;
        logic [SW-1:0] status;
    } map_result_t;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_kind          = igcm_pkg::KIND_CLEAR;
    logic signed [CW-1:0] s_point_or_left = '0;
    logic signed [CW-1:0] s_right_end     = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic signed [CW-1:0] m_mapped_value;
    logic [SW-1:0]        m_status;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int req_count      = 0;

    map_result_t mapped_due[$];

    // shadow of the interval table
    int unsigned        row_count    = 0;
    bit                 row0_written = 1'b0;
    logic signed [31:0] tab_left  [MAXI];
    logic signed [31:0] tab_right [MAXI];
    logic signed [31:0] tab_fend  [MAXI];
    logic signed [31:0] tab_disp  [MAXI];

    interval_gap_compaction_map_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_point_or_left (s_point_or_left),
        .s_right_end     (s_right_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mapped_value  (m_mapped_value),
        .m_status        (m_status)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic map_result_t map_request(input igcm_pkg::kind_t k,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        map_result_t r;
        longint      x, fe, dp, tmp;
        int          n, i;
        bit          miss;
        r.value  = '0;
        r.status = igcm_pkg::ST_OK;
        miss     = 1'b0;
        n        = row_count;
        x        = a;
        case (k)
            igcm_pkg::KIND_CLEAR: begin
                row_count = 0;
            end
            igcm_pkg::KIND_APPEND: begin
                if (n >= MAXI) begin
                    r.status = igcm_pkg::ST_FULL;
                end else if (b < a || (n > 0 && a < tab_right[n-1])) begin
                    r.status = igcm_pkg::ST_ORDER;
                end else begin
                    if (n == 0) begin
                        fe = b;
                        dp = 0;
                    end else begin
                        fe = longint'(tab_fend[n-1]) + (longint'(b) - longint'(a));
                        dp = longint'(a) - longint'(tab_fend[n-1]);
                    end
                    if (fe < Q_MIN || fe > Q_MAX || dp < Q_MIN || dp > Q_MAX) begin
                        r.status = igcm_pkg::ST_OVF;
                    end else begin
                        tab_left[n]  = a;
                        tab_right[n] = b;
                        tab_fend[n]  = fe[31:0];
                        tab_disp[n]  = dp[31:0];
                        row_count    = n + 1;
                        if (n == 0) row0_written = 1'b1;
                        r.value = fe[31:0];
                    end
                end
            end
            igcm_pkg::KIND_TO_FUSED: begin
                if (n == 1) begin
                    r.value = a;
                end else if (n == 0 || x < tab_left[0] || x > tab_right[n-1]) begin
                    miss = 1'b1;
                end else begin
                    miss = 1'b1;
                    for (i = n - 1; i >= 0; i--) begin
                        if (tab_left[i] <= x) begin
                            if (tab_right[i] >= x) begin
                                tmp     = x - longint'(tab_disp[i]);
                                r.value = tmp[31:0];
                                miss    = 1'b0;
                            end
                            break;
                        end
                    end
                end
            end
            default: begin
                if (n == 1) begin
                    r.value = a;
                end else if (n == 0 || x < tab_left[0] || x > tab_fend[n-1]) begin
                    miss = 1'b1;
                end else begin
                    miss = 1'b1;
                    for (i = 0; i < n; i++) begin
                        if (tab_fend[i] >= x) begin
                            tmp     = x + longint'(tab_disp[i]);
                            r.value = tmp[31:0];
                            miss    = 1'b0;
                            break;
                        end
                    end
                end
            end
        endcase
        if (miss) begin
            r.value  = tab_left[0] - 32'sd1;
            r.status = igcm_pkg::ST_MISS;
        end
        return r;
    endfunction

    task automatic send_req(input igcm_pkg::kind_t k, input logic [31:0] a,
                            input logic [31:0] b);
        map_result_t due;
        due = map_request(k, a, b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= k;
        s_point_or_left <= a;
        s_right_end     <= b;
        // handshake seen at the falling edge holds at the next rising edge
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        mapped_due.push_back(due);
        req_count++;
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (mapped_due.size() != 0) @(posedge aclk);
    endtask

    function automatic longint rand_span();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return longint'($urandom_range(1, 16));
            2:       return longint'($urandom_range(0, 32'h000F_FFFF));
            3:       return longint'($urandom >> $urandom_range(0, 31));
            default: return longint'($urandom_range(1, 32'h0001_0000));
        endcase
    endfunction

    // point near a stored interval, in the space the query maps from, or a random point
    function automatic logic [31:0] pick_point(input igcm_pkg::kind_t k);
        int     i;
        longint lo, hi, w, x;
        if (row_count == 0 || $urandom_range(0, 7) == 0) return $urandom;
        i  = $urandom_range(0, row_count - 1);
        hi = (k == igcm_pkg::KIND_TO_ORIG) ? longint'(tab_fend[i]) : longint'(tab_right[i]);
        w  = longint'(tab_right[i]) - longint'(tab_left[i]);
        lo = hi - w;
        case ($urandom_range(0, 4))
            0:       x = lo;
            1:       x = hi;
            2:       x = hi + 1;
            3:       x = lo - 1;
            default: x = lo + (longint'({$urandom, $urandom} >> 1) % (w + 1));
        endcase
        return x[31:0];
    endfunction

    // usually clear, build a sorted table with some broken appends, then query it
    task automatic run_interval_session();
        int              n_app, n_q, i;
        longint          cur, lo, hi;
        igcm_pkg::kind_t k;
        if ($urandom_range(0, 7) != 0) send_req(igcm_pkg::KIND_CLEAR, $urandom, $urandom);
        n_app = ($urandom_range(0, 9) == 0) ? MAXI + 2 : $urandom_range(1, 6);
        case ($urandom_range(0, 3))
            0:       cur = Q_MIN + longint'($urandom_range(0, 255));
            1:       cur = longint'(signed'($urandom));
            default: cur = longint'($urandom_range(0, 32'h00FF_FFFF)) - 64'sd8388608;
        endcase
        if (row_count != 0) cur = tab_right[row_count-1];
        for (i = 0; i < n_app; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                lo = cur - rand_span() - 1;
                hi = $urandom_range(0, 1) ? lo + rand_span() : lo - 1 - rand_span();
            end else begin
                lo = ($urandom_range(0, 3) == 0) ? cur : cur + rand_span();
                hi = lo + rand_span();
            end
            send_req(igcm_pkg::KIND_APPEND, lo[31:0], hi[31:0]);
            if (row_count != 0) cur = tab_right[row_count-1];
        end
        n_q = $urandom_range(2, 10);
        for (i = 0; i < n_q; i++) begin
            k = $urandom_range(0, 1) ? igcm_pkg::KIND_TO_FUSED : igcm_pkg::KIND_TO_ORIG;
            if (row_count == 0 && !row0_written) continue;
            send_req(k, pick_point(k), $urandom);
        end
    endtask

    task automatic test_edges();
        send_req(igcm_pkg::KIND_APPEND, QMIN32, QMIN32);
        send_req(igcm_pkg::KIND_TO_FUSED, QMAX32, $urandom);  // single interval passes through
        send_req(igcm_pkg::KIND_TO_ORIG, QMIN32, $urandom);
        send_req(igcm_pkg::KIND_APPEND, QMAX32, QMAX32);       // displacement overflows
        send_req(igcm_pkg::KIND_APPEND, QMIN32 + 10, QMIN32 + 5);  // reversed
        send_req(igcm_pkg::KIND_CLEAR, $urandom, $urandom);
        send_req(igcm_pkg::KIND_TO_FUSED, 32'd0, 32'd0);       // empty: miss value wraps
        send_req(igcm_pkg::KIND_TO_ORIG, QMAX32, QMAX32);
        send_req(igcm_pkg::KIND_APPEND, 32'd100, 32'd200);
        send_req(igcm_pkg::KIND_APPEND, 32'd200, 32'd300);     // touching
        send_req(igcm_pkg::KIND_APPEND, 32'd150, 32'd400);     // overlaps previous
        send_req(igcm_pkg::KIND_APPEND, 32'd1000, 32'd1100);
        send_req(igcm_pkg::KIND_TO_FUSED, 32'd250, 32'd0);
        send_req(igcm_pkg::KIND_TO_FUSED, 32'd1050, 32'd0);
        send_req(igcm_pkg::KIND_TO_FUSED, 32'd500, 32'd0);     // in the gap
        send_req(igcm_pkg::KIND_TO_FUSED, 32'd99, 32'd0);
        send_req(igcm_pkg::KIND_TO_FUSED, 32'd1101, 32'd0);
        send_req(igcm_pkg::KIND_TO_FUSED, 32'd1100, 32'd0);
        send_req(igcm_pkg::KIND_TO_ORIG, 32'd300, 32'd0);
        send_req(igcm_pkg::KIND_TO_ORIG, 32'd301, 32'd0);
        send_req(igcm_pkg::KIND_TO_ORIG, 32'd400, 32'd0);
        send_req(igcm_pkg::KIND_TO_ORIG, 32'd401, 32'd0);
        send_req(igcm_pkg::KIND_TO_ORIG, 32'd99, 32'd0);
    endtask

    task automatic test_table_full();
        int i;
        send_req(igcm_pkg::KIND_CLEAR, 32'd0, 32'd0);
        for (i = 0; i < MAXI; i++) begin
            send_req(igcm_pkg::KIND_APPEND, QMIN32 + i * 32'h0100_0000,
                     QMIN32 + i * 32'h0100_0000 + 32'hFFFF);
        end
        send_req(igcm_pkg::KIND_APPEND, 32'd5, 32'd0);         // full wins over unordered
        send_req(igcm_pkg::KIND_APPEND, QMAX32, QMAX32);
        send_req(igcm_pkg::KIND_TO_FUSED, QMIN32 + (MAXI - 1) * 32'h0100_0000 + 32'h10, 32'd0);
        send_req(igcm_pkg::KIND_TO_ORIG, tab_fend[MAXI-1], 32'd0);
        send_req(igcm_pkg::KIND_TO_ORIG, QMIN32, 32'd0);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
        int start;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start          = req_count;
        while (req_count - start < n_items) run_interval_session();
    endtask

    task automatic test_drain_pause();
        src_idle_pct   = 0;
        sink_stall_pct = 50;
        run_interval_session();
        hold_until_drained();
        run_interval_session();
    endtask

    always @(negedge aclk) begin : result_check
        map_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (mapped_due.size() == 0) begin
                $display("%0t unexpected result: expected none, actual value %h status %0d",
                         $time, m_mapped_value, m_status);
                mismatch_count++;
            end else begin
                want = mapped_due.pop_front();
                if (m_mapped_value !== want.value) begin
                    $display("%0t mapped_value mismatch: expected %h actual %h",
                             $time, want.value, m_mapped_value);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.status, m_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edges();
        test_table_full();
        test_random_traffic(0, 0, 425);
        test_drain_pause();
        test_random_traffic(79, 0, 425);
        test_random_traffic(0, 79, 425);
        test_random_traffic(20, 20, 425);
        hold_until_drained();
        repeat (MAXI + 8) @(posedge aclk);
        if (mismatch_count == 0 && mapped_due.size() == 0) begin
            $display("interval_gap_compaction_map_top regression: pass");
        end else begin
            $display("interval_gap_compaction_map_top regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("interval_gap_compaction_map_top regression: fail");
        $finish;
    end

endmodule

### interval_gap_compaction_map_top.f
rtl/igcm_pkg.sv
rtl/interval_gap_compaction_map_top.sv
tb/interval_gap_compaction_map_top_tb.sv
